[hw/rtl/swce_pkg.sv]
// Shared types, constants and table functions of the sliding-window composition
// entropy unit. Used by every module of the block; depends on nothing else.
`default_nettype none

package swce_pkg;

   localparam int CFG_W        = 7;         // width of the window and bogus registers
   localparam int CODE_W       = 5;         // stored residue code width
   localparam int LOG_FRAC     = 24;        // fraction bits of the internal log2 values
   localparam int LOG_W        = LOG_FRAC + 4;
   localparam int ENT_W        = 15;        // entropy field width
   localparam int ENT_MAX      = 32767;
   localparam int RSP_DATA_W   = 16;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int MIN_WINDOW   = 2;

   localparam logic [CODE_W-1:0] BOGUS_CODE = 5'd31;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } hist_ctrl_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } cnt_ctrl_type;

   // Maps an ASCII byte to a letter index of the selected alphabet, case ignored.
   function automatic logic [CODE_W-1:0] encode_residue(input logic [7:0] ch,
                                                        input logic       nucl);
      logic [7:0]        up;
      logic [CODE_W-1:0] code;
      code = BOGUS_CODE;
      up   = ch;
      if (ch >= "a" && ch <= "z") begin
         up = ch - 8'd32;
      end
      if (nucl) begin
         case (up)
            "A":     code = 5'd0;
            "C":     code = 5'd1;
            "G":     code = 5'd2;
            "T":     code = 5'd3;
            "U":     code = 5'd4;
            default: code = BOGUS_CODE;
         endcase
      end else begin
         case (up)
            "A":     code = 5'd0;
            "C":     code = 5'd1;
            "D":     code = 5'd2;
            "E":     code = 5'd3;
            "F":     code = 5'd4;
            "G":     code = 5'd5;
            "H":     code = 5'd6;
            "I":     code = 5'd7;
            "K":     code = 5'd8;
            "L":     code = 5'd9;
            "M":     code = 5'd10;
            "N":     code = 5'd11;
            "P":     code = 5'd12;
            "Q":     code = 5'd13;
            "R":     code = 5'd14;
            "S":     code = 5'd15;
            "T":     code = 5'd16;
            "V":     code = 5'd17;
            "W":     code = 5'd18;
            "Y":     code = 5'd19;
            default: code = BOGUS_CODE;
         endcase
      end
      return code;
   endfunction

   // log2(n) with LOG_FRAC fraction bits by repeated squaring of the Q30
   // mantissa. Only evaluated on constants to build lookup tables.
   function automatic logic [63:0] log2_fixed(input int unsigned n);
      int unsigned k;
      logic [63:0] y;
      logic [63:0] frac;
      k    = 0;
      frac = '0;
      if (n == 0) begin
         return '0;
      end
      for (int j = 0; j < 30; j++) begin
         if ((n >> (k + 1)) != 0) begin
            k = k + 1;
         end
      end
      y = 64'(n) << (30 - k);
      for (int i = 1; i <= LOG_FRAC; i++) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y    = y >> 1;
            frac = frac | (64'd1 << (LOG_FRAC - i));
         end
      end
      return (64'(k) << LOG_FRAC) | frac;
   endfunction

   // n * log2(n), the per-letter term of the composition sum.
   function automatic logic [63:0] ent_term(input int unsigned n);
      return 64'(n) * log2_fixed(n);
   endfunction

   // Change of the composition sum when one count moves from n-1 to n.
   function automatic logic [63:0] ent_delta(input int unsigned n);
      if (n == 0) begin
         return '0;
      end
      return ent_term(n) - ent_term(n - 1);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/swce_hist_mem.sv]
// Residue history memory: one write port, one read port, registered read data.
// Depends on swce_pkg for the control struct.
`default_nettype none

module swce_hist_mem
   import swce_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 5
) (
   input  wire logic                clock,
   input  wire hist_ctrl_type       ctrl,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [DATA_W-1:0]   rd_data,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]   wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/swce_count_mem.sv]
// Letter count memory with one valid bit per entry; an entry that is not valid
// reads as zero, so a clear needs no pass over the entries. Depends on swce_pkg.
`default_nettype none

module swce_count_mem
   import swce_pkg::*;
#(
   parameter int DEPTH  = 20,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 7
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cnt_ctrl_type        ctrl,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [DATA_W-1:0]   rd_data,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]   wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic              rd_valid_ff;
   logic              rd_valid_in;

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (ctrl.rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
      if (ctrl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctrl.clear) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[hw/rtl/swce_divider.sv]
// Iterative restoring divider, two quotient bits per cycle.
// Depends on swce_pkg only through the common import.
`default_nettype none

module swce_divider
   import swce_pkg::*;
#(
   parameter int DIVIDEND_W = 35,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int PAD_W   = DIVIDEND_W + (DIVIDEND_W % 2);
   localparam int STEPS   = PAD_W / 2;
   localparam int STEP_W  = $clog2(STEPS + 1);

   // Returns the quotient bit above the new partial remainder.
   function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] rem,
                                                   input logic                 din,
                                                   input logic [DIVISOR_W-1:0] dvs);
      logic [DIVISOR_W:0] trial;
      logic [DIVISOR_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {1'b1, diff[DIVISOR_W-1:0]};
      end
      return {1'b0, trial[DIVISOR_W-1:0]};
   endfunction

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [PAD_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   first_step;
   logic [DIVISOR_W:0]   second_step;

   always_comb begin
      first_step  = div_step(rem_ff, quo_ff[PAD_W-1], dvs_ff);
      second_step = div_step(first_step[DIVISOR_W-1:0], quo_ff[PAD_W-2], dvs_ff);
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(STEPS);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = PAD_W'(dividend);
      end else if (busy_ff) begin
         quo_in  = {quo_ff[PAD_W-3:0], first_step[DIVISOR_W], second_step[DIVISOR_W]};
         rem_in  = second_step[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/sliding_window_composition_entropy_unit.sv]
// While the window is filling, a transaction skips the eviction steps and the divider; once it
// is full, the oldest code is evicted first, and the two-bit-per-cycle divider runs only when
// the window holds a letter. One item is in flight at a time; the next transaction is taken
// once its result enters the output register.
// Reset (synchronous, active high) empties the window and restores the registers to
// window_length 12, max_bogus 2, alphabet_mode 0. The history memory is never cleared.
`default_nettype none

module sliding_window_composition_entropy_unit
   import swce_pkg::*;
#(
   parameter int MAX_WINDOW    = 64,
   parameter int ALPHABET_SIZE = 20,
   parameter int FRAC_BITS     = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] residue
   input  wire logic [0:0]            req_tuser,   // [0] sequence_start
   // Result stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [14:0] entropy, [15] zero
   output logic [0:0]                 rsp_tuser,   // [0] entropy_valid
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // Count and fill width covers the full window; the history index covers its depth.
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int HIST_W  = $clog2(MAX_WINDOW);
   localparam int LET_W   = $clog2(ALPHABET_SIZE);
   localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int SUM_W   = CNT_W + LOG_W;
   localparam int SHIFT   = LOG_FRAC - FRAC_BITS;
   localparam logic [LOG_W:0] RND_HALF = (LOG_W + 1)'(1) << (SHIFT - 1);

   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH = 2'd0,
      REG_MAX_BOGUS     = 2'd1,
      REG_ALPHABET_MODE = 2'd2
   } reg_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_EVICT_CNT,
      ST_EVICT_UPD,
      ST_ADD_RD,
      ST_ADD_UPD,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   // Constant tables: log2(n) and the step of n*log2(n), both with LOG_FRAC
   // fraction bits, for every count the window can hold.
   logic [LOG_W-1:0] log_lut [MAX_WINDOW + 1];
   logic [SUM_W-1:0] dlt_lut [MAX_WINDOW + 1];

   for (genvar n = 0; n <= MAX_WINDOW; n++) begin : g_lut
      localparam logic [63:0] LOG_VAL = log2_fixed(n);
      localparam logic [63:0] DLT_VAL = ent_delta(n);
      assign log_lut[n] = LOG_VAL[LOG_W-1:0];
      assign dlt_lut[n] = DLT_VAL[SUM_W-1:0];
   end

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   wl_ff, wl_in;
   logic [CFG_W-1:0]   maxb_ff, maxb_in;
   logic               mode_ff, mode_in;
   logic [HIST_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   bogus_ff, bogus_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENT_W-1:0]   rsp_ent_ff, rsp_ent_in;
   logic               rsp_flag_ff, rsp_flag_in;

   // Per-item working registers, no reset needed.
   logic [CODE_W-1:0]  code_ff, code_in;
   logic [CODE_W-1:0]  old_code_ff, old_code_in;
   logic [LOG_W-1:0]   lt_ff, lt_in;
   logic [LOG_W-1:0]   diff_ff, diff_in;
   logic               flag_ff, flag_in;

   hist_ctrl_type      hist_ctrl;
   logic [HIST_W-1:0]  hist_rd_addr;
   logic [CODE_W-1:0]  hist_rd_data;
   cnt_ctrl_type       cnt_ctrl;
   logic [LET_W-1:0]   cnt_rd_addr;
   logic [LET_W-1:0]   cnt_wr_addr;
   logic [CNT_W-1:0]   cnt_rd_data;
   logic [CNT_W-1:0]   cnt_wr_data;
   logic [CNT_W-1:0]   cnt_next;
   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;

   logic               csr_wr;
   reg_sel_type        reg_sel;
   logic [CFG_W-1:0]   wl_clamped;
   logic               clr_win;
   logic               req_acc;
   logic [CNT_W:0]     head_ext;
   logic [CNT_W:0]     wl_ext;
   logic [CNT_W:0]     old_pos;
   logic               window_full;
   logic [CNT_W-1:0]   total;
   logic [LOG_W:0]     rnd_sum;
   logic [LOG_W:0]     rnd_val;
   logic [ENT_W-1:0]   ent_sat;

   function automatic logic is_letter(input logic [CODE_W-1:0] code);
      return {1'b0, code} < (CODE_W + 1)'(ALPHABET_SIZE);
   endfunction

   // ---------------------------------------------------------------------
   // Register port. pready is tied high, so a write lands in the access cycle.
   // Writing the window length or the alphabet empties the window, since the
   // stored codes would no longer match.
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_sel_type'(csr_paddr[3:2]);

   always_comb begin
      wl_clamped = csr_pwdata[CFG_W-1:0];
      if (csr_pwdata[CFG_W-1:0] < CFG_W'(MIN_WINDOW)) begin
         wl_clamped = CFG_W'(MIN_WINDOW);
      end else if (CMP_W'(csr_pwdata[CFG_W-1:0]) > CMP_W'(MAX_WINDOW)) begin
         wl_clamped = CFG_W'(MAX_WINDOW);
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(wl_ff);
         REG_MAX_BOGUS:     csr_prdata = CSR_DATA_W'(maxb_ff);
         REG_ALPHABET_MODE: csr_prdata = CSR_DATA_W'(mode_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Window bookkeeping. The oldest code sits window_length entries behind
   // the write pointer in the circular history.
   // ---------------------------------------------------------------------
   assign head_ext     = (CNT_W + 1)'(head_ff);
   assign wl_ext       = (CNT_W + 1)'(wl_ff);
   assign old_pos      = (head_ext >= wl_ext) ? head_ext - wl_ext
                                              : head_ext + (CNT_W + 1)'(MAX_WINDOW) - wl_ext;
   assign hist_rd_addr = old_pos[HIST_W-1:0];
   assign window_full  = CMP_W'(fill_ff) >= CMP_W'(wl_ff);
   assign total        = (fill_ff > bogus_ff) ? fill_ff - bogus_ff : '0;
   assign cnt_next     = cnt_rd_data + CNT_W'(1);
   assign req_acc      = req_tvalid & req_tready;
   assign req_tready   = (state_ff == ST_IDLE);

   // Round half up to FRAC_BITS and saturate to the entropy field.
   assign rnd_sum = {1'b0, diff_ff} + RND_HALF;
   assign rnd_val = rnd_sum >> SHIFT;
   assign ent_sat = (rnd_val > (LOG_W + 1)'(ENT_MAX)) ? ENT_W'(ENT_MAX)
                                                     : rnd_val[ENT_W-1:0];

   // ---------------------------------------------------------------------
   // Item sequencer. Each transaction walks the states once:
   //   evict  - if full, read the oldest code, then its count, then write it back less one;
   //   add    - store the new code, read its count, write it back plus one;
   //   check  - decide whether an entropy is due and, if so, start the divider;
   //   result - round, saturate and load the output register.
   // The running sum of c*log2(c) is kept up to date with one table step per
   // count change, so no pass over the letters is needed. Each count read is
   // issued in a later state than any write to the same memory, so no forwarding
   // path exists between them.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      maxb_in      = maxb_ff;
      mode_in      = mode_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      bogus_in     = bogus_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_flag_in  = rsp_flag_ff;
      code_in      = code_ff;
      old_code_in  = old_code_ff;
      lt_in        = lt_ff;
      diff_in      = diff_ff;
      flag_in      = flag_ff;
      hist_ctrl    = '0;
      cnt_ctrl     = '0;
      cnt_rd_addr  = code_ff[LET_W-1:0];
      cnt_wr_addr  = code_ff[LET_W-1:0];
      cnt_wr_data  = cnt_next;
      div_start    = 1'b0;
      clr_win      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         case (reg_sel)
            REG_WINDOW_LENGTH: begin
               wl_in   = wl_clamped;
               clr_win = 1'b1;
            end
            REG_MAX_BOGUS: begin
               maxb_in = csr_pwdata[CFG_W-1:0];
            end
            REG_ALPHABET_MODE: begin
               mode_in = csr_pwdata[0];
               clr_win = 1'b1;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               code_in  = encode_residue(req_tdata, mode_ff);
               clr_win  = clr_win | req_tuser[0];
               state_in = ST_EVICT_RD;
            end
         end
         ST_EVICT_RD: begin
            if (window_full) begin
               hist_ctrl.rd_en = 1'b1;
               state_in        = ST_EVICT_CNT;
            end else begin
               state_in = ST_ADD_RD;
            end
         end
         ST_EVICT_CNT: begin
            old_code_in = hist_rd_data;
            cnt_rd_addr = hist_rd_data[LET_W-1:0];
            cnt_ctrl.rd_en = is_letter(hist_rd_data);
            fill_in     = CNT_W'(wl_ff) - CNT_W'(1);
            state_in    = ST_EVICT_UPD;
         end
         ST_EVICT_UPD: begin
            cnt_wr_addr = old_code_ff[LET_W-1:0];
            cnt_wr_data = cnt_rd_data - CNT_W'(1);
            if (is_letter(old_code_ff)) begin
               if (cnt_rd_data != '0) begin
                  cnt_ctrl.wr_en = 1'b1;
                  sum_in         = sum_ff - dlt_lut[cnt_rd_data];
               end
            end else if (bogus_ff != '0) begin
               bogus_in = bogus_ff - CNT_W'(1);
            end
            state_in = ST_ADD_RD;
         end
         ST_ADD_RD: begin
            hist_ctrl.wr_en = 1'b1;
            head_in  = (head_ff == HIST_W'(MAX_WINDOW - 1)) ? '0 : head_ff + HIST_W'(1);
            cnt_ctrl.rd_en = is_letter(code_ff);
            state_in = ST_ADD_UPD;
         end
         ST_ADD_UPD: begin
            if (is_letter(code_ff)) begin
               cnt_ctrl.wr_en = 1'b1;
               sum_in         = sum_ff + dlt_lut[cnt_next];
            end else begin
               bogus_in = bogus_ff + CNT_W'(1);
            end
            fill_in  = fill_ff + CNT_W'(1);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            flag_in = window_full && (CMP_W'(bogus_ff) <= CMP_W'(maxb_ff));
            lt_in   = log_lut[total];
            if (window_full && total != '0) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               // Window still filling or no letter in it: entropy reads zero.
               diff_in  = '0;
               state_in = ST_RESULT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               diff_in  = (SUM_W'(lt_ff) > div_quo) ? LOG_W'(SUM_W'(lt_ff) - div_quo) : '0;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ent_in   = ent_sat;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (clr_win) begin
         fill_in        = '0;
         bogus_in       = '0;
         head_in        = '0;
         sum_in         = '0;
         cnt_ctrl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= CFG_W'(12);
         maxb_ff      <= CFG_W'(2);
         mode_ff      <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         bogus_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ent_ff   <= '0;
         rsp_flag_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         maxb_ff      <= maxb_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         bogus_ff     <= bogus_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ent_ff   <= rsp_ent_in;
         rsp_flag_ff  <= rsp_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      old_code_ff <= old_code_in;
      lt_ff       <= lt_in;
      diff_ff     <= diff_in;
      flag_ff     <= flag_in;
   end

   // ---------------------------------------------------------------------
   // Storage and the divider.
   // ---------------------------------------------------------------------
   swce_hist_mem #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (HIST_W),
      .DATA_W (CODE_W)
   ) u_hist_mem (
      .clock   (clock),
      .ctrl    (hist_ctrl),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data),
      .wr_addr (head_ff),
      .wr_data (code_ff)
   );

   swce_count_mem #(
      .DEPTH  (ALPHABET_SIZE),
      .ADDR_W (LET_W),
      .DATA_W (CNT_W)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cnt_ctrl),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data)
   );

   // Sum of c*log2(c) divided by the letter count, truncating.
   swce_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (total),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ent_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

`default_nettype wire

[hw/rtl/swce_checker.sv]
// Port-level checks of the entropy unit, bound to its top level.
// Depends on swce_pkg for the result width.
`default_nettype none

module swce_checker
   import swce_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser
);

   // One item at a time: a transaction closes the input.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input stayed open after a transaction");

   // A result never appears right after a transaction.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared the cycle after a transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind sliding_window_composition_entropy_unit swce_checker u_swce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
